/* hw/rtl/lbrc_pkg.sv */
// shared types, constants and codes of the block read cache controller
package lbrc_pkg;

   // fixed geometry of the cache words
   localparam int BLOCK_BYTES = 262144;
   localparam int OFF_W       = $clog2(BLOCK_BYTES);
   localparam int LEN_W       = OFF_W + 1;
   localparam int ADDR_W      = 48;
   localparam int TAG_W       = ADDR_W - OFF_W;
   localparam int POS_W       = 63;
   localparam int STAMP_W     = 32;
   localparam int REQ_W       = 32;
   localparam int SEEK_W      = 64;
   localparam int SLOT_W      = 3;
   localparam int DEF_SLOTS   = 8;

   // request function codes
   localparam logic FUNC_READ = 1'b0;
   localparam logic FUNC_SEEK = 1'b1;

   // seek base codes (anything else means file end)
   localparam logic [1:0] WHENCE_START = 2'd0;
   localparam logic [1:0] WHENCE_CUR   = 2'd1;

   // result status codes
   localparam logic [1:0] STAT_OK  = 2'd0;
   localparam logic [1:0] STAT_END = 2'd1;
   localparam logic [1:0] STAT_ERR = 2'd2;

   // request word
   typedef struct packed {
      logic                     func;
      logic [REQ_W-1:0]         request_len;
      logic signed [SEEK_W-1:0] seek_offset;
      logic [1:0]               whence;
      logic [LEN_W-1:0]         fill_len;
      logic                     fill_error;
   } req_word_type;

   // response word
   typedef struct packed {
      logic [1:0]        status;
      logic [LEN_W-1:0]  served;
      logic [SLOT_W-1:0] slot;
      logic [OFF_W-1:0]  block_offset;
      logic              miss;
      logic [ADDR_W-1:0] fetch_addr;
      logic [LEN_W-1:0]  fetch_len;
      logic [POS_W-1:0]  position;
   } rsp_word_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_req;
      logic calc;
      logic seek;
      logic early_end;
      logic start;
      logic scan;
      logic fill;
      logic serve;
      logic commit;
      logic emit;
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic is_seek;
      logic past_end;
      logic zero_req;
      logic hit;
      logic scan_last;
      logic fill_error;
      logic out_free;
   } ctrl_stat_type;

endpackage

/* hw/rtl/lbrc_ctrl.sv */
// sequencing state machine of the block read cache controller
module lbrc_ctrl import lbrc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_CALC   = 8'b0000_0010,
      S_CLAMP  = 8'b0000_0100,
      S_SCAN   = 8'b0000_1000,
      S_FILL   = 8'b0001_0000,
      S_SERVE  = 8'b0010_0000,
      S_COMMIT = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_CALC;
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            if (stat.is_seek) begin
               cmd.seek = 1'b1;
               state_in = S_DONE;
            end else if (stat.past_end || stat.zero_req) begin
               cmd.early_end = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.start = 1'b1;
               state_in  = stat.hit ? S_SERVE : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            state_in = stat.fill_error ? S_DONE : S_SERVE;
         end
         S_SERVE: begin
            cmd.serve = 1'b1;
            state_in  = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/lbrc_dp.sv */
// datapath of the block read cache controller: position, slot table and result
module lbrc_dp import lbrc_pkg::*; #(
   parameter int SLOTS = DEF_SLOTS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [ADDR_W-1:0] csr_wr_data,
   input  req_word_type      req_word,
   input  ctrl_cmd_type      cmd,
   output ctrl_stat_type     stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_word_type      rsp_word
);

   localparam int IDX_W = $clog2(SLOTS);

   // architectural state
   logic [ADDR_W-1:0]  file_size_ff;
   logic [POS_W-1:0]   read_pos_ff, read_pos_in;
   logic [STAMP_W-1:0] use_tick_ff, use_tick_in;
   logic               slot_valid_ff [SLOTS];
   logic [TAG_W-1:0]   slot_tag_ff   [SLOTS];
   logic [LEN_W-1:0]   slot_len_ff   [SLOTS];
   logic [STAMP_W-1:0] slot_stamp_ff [SLOTS];

   // per item working registers
   req_word_type       req_ff;
   logic [SEEK_W:0]    sum_ff, sum_in;
   logic               past_end_ff, past_end_in;
   logic [ADDR_W-1:0]  remain_ff, remain_in;
   logic [ADDR_W-1:0]  avail_ff, avail_in;
   logic [SLOTS-1:0]   match_ff, match_in;
   logic [REQ_W-1:0]   n1_ff, n1_in;
   logic [LEN_W-1:0]   fl_ff, fl_in;
   logic [IDX_W-1:0]   slot_ff;
   logic               miss_ff;
   logic [IDX_W-1:0]   scan_idx_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [STAMP_W-1:0] best_stamp_ff;
   logic [LEN_W-1:0]   n2_ff, n2_in;
   logic [LEN_W-1:0]   span_ff, span_in;
   logic               short_ff, short_in;
   rsp_word_type       res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   // helpers
   logic [TAG_W-1:0]   cur_tag;
   logic [OFF_W-1:0]   in_off;
   logic [ADDR_W-1:0]  blk_addr;
   logic [POS_W-1:0]   seek_base;
   logic               seek_err;
   logic [IDX_W-1:0]   hit_idx;
   logic [STAMP_W-1:0] cand_stamp;
   logic               cand_better;
   logic [LEN_W-1:0]   got_len;
   logic [LEN_W-1:0]   cur_len;
   logic [LEN_W-1:0]   room;
   logic [LEN_W-1:0]   served;

   assign cur_tag  = read_pos_ff[ADDR_W-1:OFF_W];
   assign in_off   = read_pos_ff[OFF_W-1:0];
   assign blk_addr = {cur_tag, {OFF_W{1'b0}}};

   // seek target as a signed sum; negative or above the position range is an error
   always_comb begin
      case (req_ff.whence)
         WHENCE_START: seek_base = '0;
         WHENCE_CUR:   seek_base = read_pos_ff;
         default:      seek_base = POS_W'(file_size_ff);
      endcase
   end
   assign sum_in   = {2'b00, seek_base} + {req_ff.seek_offset[SEEK_W-1], req_ff.seek_offset};
   assign seek_err = sum_ff[SEEK_W] | sum_ff[SEEK_W-1];

   // read bounds against file end and block end
   assign past_end_in = read_pos_ff >= POS_W'(file_size_ff);
   assign remain_in   = file_size_ff - read_pos_ff[ADDR_W-1:0];
   assign avail_in    = file_size_ff - blk_addr;
   assign n1_in       = (ADDR_W'(req_ff.request_len) > remain_ff) ?
                        remain_ff[REQ_W-1:0] : req_ff.request_len;
   assign fl_in       = (avail_ff >= ADDR_W'(BLOCK_BYTES)) ?
                        LEN_W'(BLOCK_BYTES) : avail_ff[LEN_W-1:0];

   // tag match over all slots
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match_in[i] = slot_valid_ff[i] && (slot_tag_ff[i] == cur_tag);
      end
   end

   // lowest matching slot wins
   always_comb begin
      hit_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_idx = IDX_W'(i);
         end
      end
   end

   // victim search: one stamp per cycle, ties keep the lower slot
   assign cand_stamp  = slot_stamp_ff[scan_idx_ff];
   assign cand_better = cand_stamp < best_stamp_ff;

   // fill reply clipped to the fetch length
   assign got_len = (req_ff.fill_len > fl_ff) ? fl_ff : req_ff.fill_len;

   // serve bounds from the slot's valid length
   assign cur_len  = slot_len_ff[slot_ff];
   assign room     = LEN_W'(BLOCK_BYTES) - LEN_W'(in_off);
   assign short_in = LEN_W'(in_off) >= cur_len;
   assign span_in  = cur_len - LEN_W'(in_off);
   assign n2_in    = (n1_ff > REQ_W'(room)) ? room : n1_ff[LEN_W-1:0];
   assign served   = (n2_ff > span_ff) ? span_ff : n2_ff;

   // position and tick updates
   always_comb begin
      read_pos_in = read_pos_ff;
      use_tick_in = use_tick_ff;
      if (cmd.seek && !seek_err) begin
         read_pos_in = sum_ff[POS_W-1:0];
      end else if (cmd.commit && !short_ff) begin
         read_pos_in = read_pos_ff + POS_W'(served);
         use_tick_in = use_tick_ff + STAMP_W'(1);
      end
   end

   // result assembly; position is added when the word is sent
   always_comb begin
      res_in = res_ff;
      if (cmd.seek) begin
         res_in        = '0;
         res_in.status = seek_err ? STAT_ERR : STAT_OK;
      end else if (cmd.early_end) begin
         res_in        = '0;
         res_in.status = STAT_END;
      end else if (cmd.fill && req_ff.fill_error) begin
         res_in              = '0;
         res_in.status       = STAT_ERR;
         res_in.slot         = SLOT_W'(best_idx_ff);
         res_in.block_offset = in_off;
         res_in.miss         = 1'b1;
         res_in.fetch_addr   = blk_addr;
         res_in.fetch_len    = fl_ff;
      end else if (cmd.commit) begin
         res_in              = '0;
         res_in.status       = short_ff ? STAT_END : STAT_OK;
         res_in.served       = short_ff ? '0 : served;
         res_in.slot         = SLOT_W'(slot_ff);
         res_in.block_offset = in_off;
         res_in.miss         = miss_ff;
         res_in.fetch_addr   = miss_ff ? blk_addr : '0;
         res_in.fetch_len    = miss_ff ? fl_ff : '0;
      end
   end

   // outgoing word with the current position
   always_comb begin
      rsp_word_in          = res_ff;
      rsp_word_in.position = read_pos_ff;
   end

   // output register handshake
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // status to the controller
   assign stat.is_seek    = (req_ff.func == FUNC_SEEK);
   assign stat.past_end   = past_end_ff;
   assign stat.zero_req   = (req_ff.request_len == '0);
   assign stat.hit        = |match_ff;
   assign stat.scan_last  = (scan_idx_ff == IDX_W'(SLOTS - 1));
   assign stat.fill_error = req_ff.fill_error;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // control state and slot table with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         file_size_ff <= '0;
         read_pos_ff  <= '0;
         use_tick_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_valid_ff[i] <= 1'b0;
            slot_len_ff[i]   <= '0;
            slot_stamp_ff[i] <= '0;
         end
      end else begin
         read_pos_ff  <= read_pos_in;
         use_tick_ff  <= use_tick_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            file_size_ff <= csr_wr_data;
         end
         if (cmd.fill) begin
            slot_valid_ff[best_idx_ff] <= !req_ff.fill_error;
            if (!req_ff.fill_error) begin
               slot_len_ff[best_idx_ff] <= got_len;
            end
         end
         if (cmd.commit && !short_ff) begin
            slot_stamp_ff[slot_ff] <= use_tick_in;
         end
      end
   end

   // working registers and payload
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_word;
      end
      if (cmd.calc) begin
         sum_ff      <= sum_in;
         past_end_ff <= past_end_in;
         remain_ff   <= remain_in;
         avail_ff    <= avail_in;
         match_ff    <= match_in;
      end
      if (cmd.start) begin
         n1_ff         <= n1_in;
         fl_ff         <= fl_in;
         slot_ff       <= hit_idx;
         miss_ff       <= 1'b0;
         best_idx_ff   <= '0;
         best_stamp_ff <= slot_stamp_ff[0];
         scan_idx_ff   <= IDX_W'(1);
      end
      if (cmd.scan) begin
         if (cand_better) begin
            best_idx_ff   <= scan_idx_ff;
            best_stamp_ff <= cand_stamp;
         end
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
      end
      if (cmd.fill) begin
         slot_ff <= best_idx_ff;
         miss_ff <= 1'b1;
         if (!req_ff.fill_error) begin
            slot_tag_ff[best_idx_ff] <= cur_tag;
         end
      end
      if (cmd.serve) begin
         n2_ff    <= n2_in;
         span_ff  <= span_in;
         short_ff <= short_in;
      end
      res_ff <= res_in;
      if (cmd.emit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

/* hw/rtl/lru_block_read_cache_unit.sv */
// top level of the fully associative lru block read cache controller
//
// req channel (valid/ready) carries one request word: a read of request_len
// bytes at the current position, or a seek from start, current position or
// file end. The backing store's reply to a possible block fetch (fill_len,
// fill_error) travels in the same word. rsp channel (valid/ready) returns one
// word per request: status, bytes served, slot, offset in block, fetch details
// and the position after the request. csr_wr_en/csr_wr_data set the file size.
// From acceptance, a seek or a read that stops at file end or asks for nothing
// passes CALC, CLAMP and DONE; a hit passes CALC, CLAMP, SERVE, COMMIT and DONE;
// a miss adds SCAN and FILL before SERVE, and a failed fetch goes from FILL to
// DONE; the victim search reads one slot stamp per cycle. One request is in
// work at a time, so the next word is taken in the cycle after the previous
// result enters the output register. A result waiting on a stalled receiver
// does not block acceptance of the next word, which then waits for the output
// register before its result is loaded. Reset clears the position, the file
// size, the use counter, all slot valid flags and stamps, and the output.
module lru_block_read_cache_unit import lbrc_pkg::*; #(
   parameter int SLOTS = DEF_SLOTS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_word_type      req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_word_type      rsp_word,
   input  logic              csr_wr_en,
   input  logic [ADDR_W-1:0] csr_wr_data
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // sequencer
   lbrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   lbrc_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_word    (req_word),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

endmodule
